### rtl/core/cds_pkg.sv
// Shared types, constants and helper functions for the calendar date stepper.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package cds_pkg;

  localparam int CDS_MAX_YEAR   = 9999;
  localparam int CDS_COUNT_BITS = 12;

  // floor(x / 100) for x < 43690 as (x * K) >> SH
  localparam int CDS_DIV100_K  = 20972;
  localparam int CDS_DIV100_SH = 21;
  localparam int CDS_CENTURY   = 100;
  // floor(x / 7) for x < 1638 as (x * K) >> SH
  localparam int CDS_DIV7_K    = 1171;
  localparam int CDS_DIV7_SH   = 13;
  localparam int CDS_WEEK      = 7;
  // 400-year offset keeps the weekday and keeps the shifted year positive
  localparam int CDS_ZELLER_OFS = 400;
  // register stages in the weekday pipe
  localparam int CDS_WD_LAT = 5;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_SUB   = 2'd2,
    CMD_QUERY = 2'd3
  } cds_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_WAIT,
    ST_DONE
  } cds_state_t;

  typedef struct packed {
    logic capture;   // take the input item, apply a load
    logic step;      // one day step (direction from captured cmd)
    logic latch_out; // move date and weekday into the output register
  } cds_ctl_t;

  typedef struct packed {
    logic done;      // no more steps left for the current item
  } cds_stat_t;

  function automatic logic [4:0] cds_month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    begin
      case (m)
        4'd2:                      len = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
        default:                   len = 5'd31;
      endcase
      return len;
    end
  endfunction

  // floor(2.6 * m' - 0.2), m' = month shifted so March is 1
  function automatic logic [4:0] cds_month_term(input logic [3:0] m);
    logic [4:0] t;
    begin
      case (m)
        4'd1:    t = 5'd28;
        4'd2:    t = 5'd31;
        4'd3:    t = 5'd2;
        4'd4:    t = 5'd5;
        4'd5:    t = 5'd7;
        4'd6:    t = 5'd10;
        4'd7:    t = 5'd12;
        4'd8:    t = 5'd15;
        4'd9:    t = 5'd18;
        4'd10:   t = 5'd20;
        4'd11:   t = 5'd23;
        4'd12:   t = 5'd25;
        default: t = 5'd0;
      endcase
      return t;
    end
  endfunction

endpackage

### rtl/core/calendar_date_stepper.sv
// Calendar date stepper: holds a Gregorian date, loads / steps / queries it
// and reports the date with its weekday. Top level; uses cds_pkg, cds_ctrl
// and cds_datapath.
//
// Input channel in_valid / in_stall with cmd, load_day, load_month, load_year,
// day_count. Output channel out_valid / out_stall with out_day, out_month,
// out_year, weekday, range_error. An item moves on a clock edge with valid
// high and stall low. Every input item gives exactly one result item.
// One item is worked at a time: in_stall is high from accept until the result
// has gone into the output register.
// After accept, the controller passes through ST_STEP, ST_WAIT and ST_DONE.
// For add and subtract ST_STEP is the step loop, which moves the date by one
// day per clock, up to day_count days; ST_WAIT lets the weekday pipe settle;
// ST_DONE waits until the output register is free.
// The next item can be taken in the cycle after a result is latched.
// A stalled result stays in the output register; the next input item is
// taken meanwhile and its result waits until the register is free.
// Synchronous reset sets the date to 1 January of year 1 and empties both
// channels.

`timescale 1ns / 1ps

module calendar_date_stepper #(
  parameter int COUNT_BITS = cds_pkg::CDS_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            cmd,
  input  logic [4:0]            load_day,
  input  logic [3:0]            load_month,
  input  logic [13:0]           load_year,
  input  logic [COUNT_BITS-1:0] day_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [4:0]            out_day,
  output logic [3:0]            out_month,
  output logic [13:0]           out_year,
  output logic [2:0]            weekday,
  output logic                  range_error
);
  import cds_pkg::*;

  cds_ctl_t  ctl;
  cds_stat_t stat;

  cds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .stat      (stat)
  );

  cds_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cmd         (cmd),
    .load_day    (load_day),
    .load_month  (load_month),
    .load_year   (load_year),
    .day_count   (day_count),
    .out_day     (out_day),
    .out_month   (out_month),
    .out_year    (out_year),
    .weekday     (weekday),
    .range_error (range_error)
  );

endmodule

### rtl/core/cds_ctrl.sv
// Controller for the calendar date stepper: sequences accept, day steps,
// weekday settle time and result hand-off. Depends on cds_pkg.
`timescale 1ns / 1ps

module cds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output cds_pkg::cds_ctl_t ctl,
  input  cds_pkg::cds_stat_t stat
);
  import cds_pkg::*;

  localparam int WCW = (CDS_WD_LAT > 1) ? $clog2(CDS_WD_LAT) : 1;

  cds_state_t     state, state_next;
  logic [WCW-1:0] wait_cnt, wait_cnt_next;
  logic           out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_STEP;
      ST_STEP: if (stat.done) state_next = ST_WAIT;
      ST_WAIT: if (wait_cnt == WCW'(CDS_WD_LAT - 1)) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    in_stall      = 1'b1;
    wait_cnt_next = '0;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        ctl.capture = in_valid;
      end
      ST_STEP: ctl.step = 1'b1;
      ST_WAIT: wait_cnt_next = wait_cnt + WCW'(1);
      ST_DONE: ctl.latch_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wait_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      wait_cnt <= wait_cnt_next;
      if (ctl.latch_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/cds_datapath.sv
// Datapath for the calendar date stepper: date registers, day counter,
// leap-year pipe, Zeller weekday pipe and result register. Depends on cds_pkg.
`timescale 1ns / 1ps

module cds_datapath #(
  parameter int COUNT_BITS = cds_pkg::CDS_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cds_pkg::cds_ctl_t     ctl,
  output cds_pkg::cds_stat_t    stat,
  input  logic [1:0]            cmd,
  input  logic [4:0]            load_day,
  input  logic [3:0]            load_month,
  input  logic [13:0]           load_year,
  input  logic [COUNT_BITS-1:0] day_count,
  output logic [4:0]            out_day,
  output logic [3:0]            out_month,
  output logic [13:0]           out_year,
  output logic [2:0]            weekday,
  output logic                  range_error
);
  import cds_pkg::*;

  // current date and item context
  logic [4:0]            day;
  logic [3:0]            month;
  logic [13:0]           year;
  logic [COUNT_BITS-1:0] cnt;
  cds_cmd_e              cmd_r;
  logic                  err;

  // leap flag, registered via ly_q and ly_y, then leap; years only change far from February
  logic [29:0] ly_prod;
  logic [7:0]  ly_q;
  logic [13:0] ly_y;
  logic [13:0] ly_cent;
  logic        leap;

  assign ly_prod = 30'(year) * 30'(CDS_DIV100_K);
  assign ly_cent = 14'(ly_q) * 14'(CDS_CENTURY);

  always_ff @(posedge clk) begin
    ly_q <= ly_prod[CDS_DIV100_SH+7:CDS_DIV100_SH];
    ly_y <= year;
    leap <= (ly_y[1:0] == 2'd0) && ((ly_y != ly_cent) || (ly_q[1:0] == 2'd0));
  end

  // day step decode
  logic [4:0] mlen, prev_len;
  logic       is_step, cnt_zero, fwd_wrap, back_wrap, fwd_lim, back_lim, at_lim;

  assign mlen      = cds_month_len(month, leap);
  assign prev_len  = cds_month_len(month - 4'd1, leap);
  assign fwd_wrap  = (day >= mlen);
  assign back_wrap = (day <= 5'd1);
  assign fwd_lim   = fwd_wrap && (month >= 4'd12) && (year >= 14'(CDS_MAX_YEAR));
  assign back_lim  = back_wrap && (month <= 4'd1) && (year == 14'd0);
  assign is_step   = (cmd_r == CMD_ADD) || (cmd_r == CMD_SUB);
  assign cnt_zero  = (cnt == '0);
  assign at_lim    = (cmd_r == CMD_ADD) ? fwd_lim : back_lim;
  assign stat.done = !is_step || cnt_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      day   <= 5'd1;
      month <= 4'd1;
      year  <= 14'd1;
      cnt   <= '0;
      cmd_r <= CMD_QUERY;
      err   <= 1'b0;
    end else if (ctl.capture) begin
      cmd_r <= cds_cmd_e'(cmd);
      cnt   <= day_count;
      err   <= 1'b0;
      if (cmd == CMD_LOAD) begin
        if (load_day != 5'd0) day <= load_day;
        if (load_month inside {[4'd1:4'd12]}) month <= load_month;
        if (load_year <= 14'(CDS_MAX_YEAR)) year <= load_year;
      end
    end else if (ctl.step && is_step && !cnt_zero) begin
      if (at_lim) begin
        // stop at the year limit, drop the remaining steps
        err <= 1'b1;
        cnt <= '0;
      end else begin
        cnt <= cnt - COUNT_BITS'(1);
        if (cmd_r == CMD_ADD) begin
          if (fwd_wrap) begin
            day <= 5'd1;
            if (month >= 4'd12) begin
              month <= 4'd1;
              year  <= year + 14'd1;
            end else begin
              month <= month + 4'd1;
            end
          end else begin
            day <= day + 5'd1;
          end
        end else begin
          if (back_wrap) begin
            if (month <= 4'd1) begin
              month <= 4'd12;
              year  <= year - 14'd1;
              day   <= 5'd31;
            end else begin
              month <= month - 4'd1;
              day   <= prev_len;
            end
          end else begin
            day <= day - 5'd1;
          end
        end
      end
    end
  end

  // Zeller weekday pipe, free running on the date registers
  logic [14:0] az;
  logic [29:0] s_prod;
  logic [14:0] w1_az;
  logic [7:0]  w1_s;
  logic [4:0]  w1_day, w1_t;
  logic [14:0] e_full;
  logic [6:0]  w2_e;
  logic [10:0] w2_p;
  logic [10:0] w3_j;
  logic [21:0] q7_prod;
  logic [7:0]  w4_q;
  logic [10:0] w4_j;
  logic [10:0] wd_full;
  logic [2:0]  wd;

  // January and February count as months 11 and 12 of the previous year
  assign az      = 15'(year) + 15'(CDS_ZELLER_OFS) - ((month <= 4'd2) ? 15'd1 : 15'd0);
  assign s_prod  = 30'(az) * 30'(CDS_DIV100_K);
  assign e_full  = w1_az - 15'(w1_s) * 15'(CDS_CENTURY);
  assign q7_prod = 22'(w3_j) * 22'(CDS_DIV7_K);
  assign wd_full = w4_j - 11'(w4_q) * 11'(CDS_WEEK);

  always_ff @(posedge clk) begin
    w1_az  <= az;
    w1_s   <= s_prod[CDS_DIV100_SH+7:CDS_DIV100_SH];
    w1_day <= day;
    w1_t   <= cds_month_term(month);
    w2_e   <= e_full[6:0];
    // -2*s is taken as +5*s mod 7
    w2_p   <= 11'(w1_day) + 11'(w1_t) + 11'(w1_s >> 2) + 11'(w1_s) * 11'(5);
    w3_j   <= w2_p + 11'(w2_e) + 11'(w2_e >> 2);
    w4_q   <= q7_prod[CDS_DIV7_SH+7:CDS_DIV7_SH];
    w4_j   <= w3_j;
    wd     <= wd_full[2:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_out) begin
      out_day     <= day;
      out_month   <= month;
      out_year    <= year;
      weekday     <= wd;
      range_error <= err;
    end
  end

endmodule

### rtl/core/cds_checker.sv
// Port-level checks for the calendar date stepper, bound to the top level.
// Depends on cds_pkg and calendar_date_stepper.
`timescale 1ns / 1ps

module cds_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_day,
  input logic [3:0]  out_month,
  input logic [13:0] out_year,
  input logic [2:0]  weekday,
  input logic        range_error
);
  import cds_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_day) && $stable(out_month)
      && $stable(out_year) && $stable(weekday) && $stable(range_error))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after accept");

  a_weekday: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> weekday < 3'(CDS_WEEK))
    else $error("weekday out of range");

  a_date: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day != 5'd0)
      && (out_year <= 14'(CDS_MAX_YEAR)))
    else $error("result date out of range");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_day     (out_day),
  .out_month   (out_month),
  .out_year    (out_year),
  .weekday     (weekday),
  .range_error (range_error)
);
